FILE: design/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types for the two-stack queue: operation and status codes, result
// selection, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tsq_pkg;

	// Operation codes carried by an input beat
	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	// Status codes returned with each result beat
	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} sts_code_t;

	// What the pending result register is loaded with
	typedef enum logic [1:0] {
		RES_OK    = 2'd0,
		RES_FULL  = 2'd1,
		RES_EMPTY = 2'd2,
		RES_DATA  = 2'd3
	} res_sel_t;

	// Controller -> datapath
	typedef struct packed {
		logic     latch_in;   // capture input beat
		logic     enq_write;  // push input word on input stack
		logic     xfer_rd;    // pop input stack (read issued)
		logic     xfer_wr;    // push read word on output stack
		logic     pop;        // drop top of output stack
		logic     set_res;    // load pending result
		res_sel_t res_sel;
		logic     load_out;   // move pending result to output register
	} tsq_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		op_t  op;
		logic in_full;
		logic in_empty;
		logic out_empty;
	} tsq_sts_t;

endpackage

FILE: design/tsq_ram.sv
// ----------------------------------------------------------------------------
// tsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/tsq_datapath.sv
// ----------------------------------------------------------------------------
// tsq_datapath
// Stack memories, stack counters, input capture and result registers.
// ----------------------------------------------------------------------------
module tsq_datapath #(
	parameter int STACK_DEPTH = 128,
	parameter int DATA_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsq_pkg::tsq_cmd_t  cmd,
	output tsq_pkg::tsq_sts_t  sts,
	input  logic [1:0]         operation,
	input  logic signed [31:0] value,
	output logic signed [31:0] result_value,
	output logic [1:0]         status
);
	import tsq_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	op_t                    op_q;
	logic [31:0]            value_q;
	logic [CNT_W-1:0]       in_count_q;
	logic [CNT_W-1:0]       out_count_q;
	logic [CNT_W-1:0]       in_cnt_m1;
	logic [CNT_W-1:0]       out_cnt_m1;
	logic [DATA_WIDTH-1:0]  in_wdata;
	logic [DATA_WIDTH-1:0]  in_rdata;
	logic [DATA_WIDTH-1:0]  out_rdata;
	logic [DATA_WIDTH-1:0]  res_word;
	logic [31:0]            res_word32;
	logic [31:0]            res_value_q;
	sts_code_t              res_sts_q;
	logic [31:0]            out_value_q;
	sts_code_t              out_sts_q;

	assign in_cnt_m1  = in_count_q - CNT_W'(1);
	assign out_cnt_m1 = out_count_q - CNT_W'(1);

	// word width conversion between the 32-bit ports and the stored width
	generate
		if (DATA_WIDTH > 32) begin : g_wide
			assign in_wdata   = {{(DATA_WIDTH - 32){1'b0}}, value_q};
			assign res_word32 = res_word[31:0];
		end else if (DATA_WIDTH == 32) begin : g_equal
			assign in_wdata   = value_q;
			assign res_word32 = res_word;
		end else begin : g_narrow
			assign in_wdata   = value_q[DATA_WIDTH-1:0];
			assign res_word32 = {{(32 - DATA_WIDTH){1'b0}}, res_word};
		end
	endgenerate

	// input stack: push at count, read top every cycle
	tsq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_in_ram (
		.clk   (clk),
		.we    (cmd.enq_write),
		.waddr (in_count_q[ADDR_W-1:0]),
		.wdata (in_wdata),
		.raddr (in_cnt_m1[ADDR_W-1:0]),
		.rdata (in_rdata)
	);

	// output stack: filled from input stack read data, read top every cycle
	tsq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_out_ram (
		.clk   (clk),
		.we    (cmd.xfer_wr),
		.waddr (out_count_q[ADDR_W-1:0]),
		.wdata (in_rdata),
		.raddr (out_cnt_m1[ADDR_W-1:0]),
		.rdata (out_rdata)
	);

	// stack occupancy counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= '0;
			out_count_q <= '0;
		end else begin
			if (cmd.enq_write) begin
				in_count_q <= in_count_q + CNT_W'(1);
			end else if (cmd.xfer_rd) begin
				in_count_q <= in_cnt_m1;
			end
			if (cmd.xfer_wr) begin
				out_count_q <= out_count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				out_count_q <= out_cnt_m1;
			end
		end
	end

	// result word select
	always_comb begin
		case (cmd.res_sel)
			RES_EMPTY: res_word = '1;
			RES_DATA:  res_word = out_rdata;
			default:   res_word = '0;
		endcase
	end

	// input capture, pending result, output register
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q    <= op_t'(operation);
			value_q <= value;
		end
		if (cmd.set_res) begin
			res_value_q <= res_word32;
			unique case (cmd.res_sel)
				RES_FULL:  res_sts_q <= STS_FULL;
				RES_EMPTY: res_sts_q <= STS_EMPTY;
				default:   res_sts_q <= STS_OK;
			endcase
		end
		if (cmd.load_out) begin
			out_value_q <= res_value_q;
			out_sts_q   <= res_sts_q;
		end
	end

	assign sts.op        = op_q;
	assign sts.in_full   = (in_count_q == CNT_W'(STACK_DEPTH));
	assign sts.in_empty  = (in_count_q == '0);
	assign sts.out_empty = (out_count_q == '0);

	assign result_value = out_value_q;
	assign status       = out_sts_q;

endmodule

FILE: design/tsq_ctrl.sv
// ----------------------------------------------------------------------------
// tsq_ctrl
// Controller for the two-stack queue: sequences enqueue, transfer, read and
// result handoff, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module tsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tsq_pkg::tsq_sts_t sts,
	output tsq_pkg::tsq_cmd_t cmd
);
	import tsq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_XFER,
		ST_READ,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rd_pend_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.op)
					OP_ENQ: begin
						cmd.set_res   = 1'b1;
						cmd.res_sel   = sts.in_full ? RES_FULL : RES_OK;
						cmd.enq_write = !sts.in_full;
						state_d       = ST_DONE;
					end
					OP_DEQ, OP_PEEK: begin
						if (!sts.out_empty) begin
							// top address already on the read port
							state_d = ST_READ;
						end else if (!sts.in_empty) begin
							state_d = ST_XFER;
						end else begin
							cmd.set_res = 1'b1;
							cmd.res_sel = RES_EMPTY;
							state_d     = ST_DONE;
						end
					end
					default: begin
						cmd.set_res = 1'b1;
						cmd.res_sel = RES_OK;
						state_d     = ST_DONE;
					end
				endcase
			end
			ST_XFER: begin
				// pop input stack and push previous read word, overlapped
				cmd.xfer_rd = !sts.in_empty;
				cmd.xfer_wr = rd_pend_q;
				if (sts.in_empty && !rd_pend_q) begin
					state_d = ST_EXEC;
				end
			end
			ST_READ: begin
				cmd.set_res = 1'b1;
				cmd.res_sel = RES_DATA;
				cmd.pop     = (sts.op == OP_DEQ);
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= (state_q == ST_XFER) && cmd.xfer_rd;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: design/two_stack_queue_core.sv
// ----------------------------------------------------------------------------
// two_stack_queue_core
// FIFO queue built from an input stack and an output stack in two RAMs.
//
//   channel  direction  signals                      beat content
//   in       sink       in_valid / in_ready          operation, value
//   out      source     out_valid / out_ready        result_value, status
//
// Enqueue, unknown operation or empty queue: each beat is accepted, executed
// and handed off. Dequeue/peek with a non-empty output stack adds a read
// step for the registered read of the output stack RAM. A dequeue/peek that
// finds the output stack empty first moves the input stack across at one
// entry per cycle, with a read lead-in, a write tail, an idle check and a
// re-execute; each entry moves only once.
// Reset clears the controller state and the stack counters; the RAMs are
// not cleared.
// The result waits in an output register; the next beat is accepted
// meanwhile, and only its hand-off stalls until out_ready frees the register.
// ----------------------------------------------------------------------------
module two_stack_queue_core #(
	parameter int STACK_DEPTH = 128,
	parameter int DATA_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]         status
);
	import tsq_pkg::*;

	tsq_cmd_t cmd;
	tsq_sts_t sts;

	// sequencing and handshakes
	tsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// stacks, counters and result registers
	tsq_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.value        (value),
		.result_value (result_value),
		.status       (status)
	);

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb - regression bench for two_stack_queue_core
// Sends enqueue, dequeue, peek and unknown-op beats through the in channel and
// checks every out beat against a shadow of the two stacks, held in the bench
// and updated on each accepted beat. Covers the empty queue, full input
// stack (with room left on the output stack), the longest stack transfer and
// random traffic. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsq_pkg::*;

	localparam int DEPTH       = 128;
	localparam int QUIET_LIMIT = 2000;
	localparam int NOTE_LIMIT  = 40;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_PATTERN, SINK_SLOW} sink_mode_t;

	// One expected out beat
	typedef struct {
		logic [31:0] word;
		sts_code_t   code;
	} answer_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic [1:0]         operation    = OP_NOP;
	logic signed [31:0] value        = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         status;

	// Shadow stacks
	logic [31:0] shadow_in[DEPTH];
	logic [31:0] shadow_out[DEPTH];
	int          shadow_in_cnt  = 0;
	int          shadow_out_cnt = 0;

	answer_t     due_answers[$];
	answer_t     got;

	// Traffic shaping
	sink_mode_t  sink_mode  = SINK_OPEN;
	int          gap_max    = 0;
	int          burst_left = 0;
	int          sink_tick  = 0;
	int          quiet      = 0;

	// Run statistics
	int          fail_count   = 0;
	int          beats_by_op[4];
	int          checked      = 0;
	int          full_drops   = 0;
	int          empty_hits   = 0;
	int          deepest_in   = 0;

	two_stack_queue_core #(
		.STACK_DEPTH(DEPTH),
		.DATA_WIDTH (32)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_value(result_value),
		.status      (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow of the queue: apply one accepted beat, queue its answer
	task automatic model_queue_op(input op_t op, input logic [31:0] word);
		answer_t ans;
		ans.word = '0;
		ans.code = STS_OK;
		case (op)
			OP_ENQ: begin
				if (shadow_in_cnt >= DEPTH) begin
					ans.code = STS_FULL;
					full_drops++;
				end else begin
					shadow_in[shadow_in_cnt] = word;
					shadow_in_cnt++;
					if (shadow_in_cnt > deepest_in)
						deepest_in = shadow_in_cnt;
				end
			end
			OP_DEQ, OP_PEEK: begin
				// refill the output stack, oldest entry ends on top
				if (shadow_out_cnt == 0) begin
					while (shadow_in_cnt > 0 && shadow_out_cnt < DEPTH) begin
						shadow_in_cnt--;
						shadow_out[shadow_out_cnt] = shadow_in[shadow_in_cnt];
						shadow_out_cnt++;
					end
				end
				if (shadow_out_cnt == 0) begin
					ans.word = '1;
					ans.code = STS_EMPTY;
					empty_hits++;
				end else begin
					ans.word = shadow_out[shadow_out_cnt - 1];
					if (op == OP_DEQ)
						shadow_out_cnt--;
				end
			end
			default: ;
		endcase
		due_answers.push_back(ans);
	endtask

	task automatic note_error(input string msg);
		fail_count++;
		if (fail_count <= NOTE_LIMIT)
			$display("%0t: %s", $time, msg);
	endtask

	// Send one beat; holds valid across back-to-back beats of a burst
	task automatic send_beat(input op_t op, input logic [31:0] word);
		if (gap_max > 0 && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(gap_max, 1)) @(posedge clk);
			burst_left = $urandom_range(12, 1);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid  <= 1'b1;
		operation <= op;
		value     <= word;
		do @(posedge clk); while (!in_ready);
		beats_by_op[op]++;
		model_queue_op(op, word);
	endtask

	// Sender holds off until every answer has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (due_answers.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(input int enq_pct, input int deq_pct, input int peek_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < enq_pct)
			return OP_ENQ;
		if (roll < enq_pct + deq_pct)
			return OP_DEQ;
		if (roll < enq_pct + deq_pct + peek_pct)
			return OP_PEEK;
		return OP_NOP;
	endfunction

	// Receiver stall pattern
	always @(posedge clk) begin
		sink_tick <= sink_tick + 1;
		case (sink_mode)
			SINK_OPEN:    out_ready <= 1'b1;
			SINK_COIN:    out_ready <= 1'($urandom_range(1));
			SINK_PATTERN: out_ready <= (sink_tick % 13) >= 5;
			default:      out_ready <= ($urandom_range(3) == 0);
		endcase
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			checked++;
			if (due_answers.size() == 0) begin
				note_error($sformatf("unexpected beat: result_value %h status %0d",
					result_value, status));
			end else begin
				got = due_answers.pop_front();
				if (result_value !== got.word)
					note_error($sformatf("result_value: expected %h, actual %h",
						got.word, result_value));
				if (status !== got.code)
					note_error($sformatf("status: expected %0d, actual %0d",
						got.code, status));
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d answers pending",
				$time, QUIET_LIMIT, due_answers.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Empty queue answers and unknown operations
	task automatic test_empty_queue();
		send_beat(OP_DEQ, 32'h1234_5678);
		send_beat(OP_PEEK, 32'h0);
		send_beat(OP_NOP, 32'hFFFF_FFFF);
		send_beat(OP_NOP, 32'h0);
	endtask

	// Order through a transfer, with an enqueue landing mid-drain
	task automatic test_fifo_order();
		send_beat(OP_ENQ, 32'h7FFF_FFFF);
		send_beat(OP_ENQ, 32'h8000_0000);
		send_beat(OP_ENQ, 32'h0000_0000);
		send_beat(OP_ENQ, 32'hFFFF_FFFF);
		send_beat(OP_ENQ, 32'h5555_5555);
		send_beat(OP_ENQ, 32'hAAAA_AAAA);
		send_beat(OP_PEEK, 32'h0);
		send_beat(OP_DEQ, 32'h0);
		send_beat(OP_ENQ, 32'h0000_0001);
		repeat (6) send_beat(OP_DEQ, $urandom);
		send_beat(OP_DEQ, 32'h0);
		send_beat(OP_PEEK, 32'h0);
	endtask

	// Input stack full with room on the output stack, then both stacks full
	task automatic test_input_full();
		repeat (5) send_beat(OP_ENQ, pick_word());
		send_beat(OP_DEQ, $urandom);
		repeat (DEPTH) send_beat(OP_ENQ, pick_word());
		repeat (3) send_beat(OP_ENQ, pick_word());
		repeat (4) send_beat(OP_DEQ, $urandom);
		// longest transfer: a full input stack moves across
		send_beat(OP_PEEK, $urandom);
		repeat (DEPTH) send_beat(OP_ENQ, pick_word());
		repeat (2) send_beat(OP_ENQ, pick_word());
		repeat (2 * DEPTH) send_beat(OP_DEQ, $urandom);
		repeat (2) send_beat(OP_DEQ, $urandom);
		send_beat(OP_PEEK, $urandom);
	endtask

	// Random traffic in segments, alternating enqueue and dequeue pressure
	task automatic test_random_mix();
		int enq_pct;
		int deq_pct;
		int peek_pct;
		for (int seg = 0; seg < 7; seg++) begin
			case (seg % 3)
				0: begin
					enq_pct = 40; deq_pct = 30; peek_pct = 20;
				end
				1: begin
					enq_pct = 75; deq_pct = 10; peek_pct = 10;
				end
				default: begin
					enq_pct = 20; deq_pct = 55; peek_pct = 20;
				end
			endcase
			if (seg == 2) begin
				gap_max   = 0;
				sink_mode = SINK_OPEN;
			end else begin
				gap_max   = $urandom_range(8);
				sink_mode = sink_mode_t'($urandom_range(3));
			end
			if (seg == 4)
				wait_drained();
			repeat (190) send_beat(pick_op(enq_pct, deq_pct, peek_pct), pick_word());
		end
	endtask

	initial begin
		for (int i = 0; i < 4; i++)
			beats_by_op[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_max   = 0;
		sink_mode = SINK_OPEN;
		test_empty_queue();
		sink_mode = SINK_PATTERN;
		test_fifo_order();
		wait_drained();

		gap_max   = 6;
		sink_mode = SINK_COIN;
		test_input_full();
		wait_drained();

		test_random_mix();

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d beats: %0d enqueue, %0d dequeue, %0d peek, %0d unknown op",
			beats_by_op[0] + beats_by_op[1] + beats_by_op[2] + beats_by_op[3],
			beats_by_op[0], beats_by_op[1], beats_by_op[2], beats_by_op[3]);
		$display("Checked %0d results; %0d full drops, %0d empty answers, input stack peak %0d",
			checked, full_drops, empty_hits, deepest_in);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
